// ----- hw/rtl/lgps_pkg.sv -----
// Shared constants and types for the gait phase scheduler.
package lgps_pkg;

    localparam int MAX_SEGMENTS        = 16;
    localparam int LEG_COUNT           = 4;
    localparam int PHASE_FRACTION_BITS = 16;

    localparam int LEGS      = 4;
    localparam int LANES     = 2 * LEGS;
    localparam int TICK_W    = 32;
    localparam int TPS_W     = 8;
    localparam int CNT_W     = 5;
    localparam int OFF_W     = 4;
    localparam int DUR_W     = 5;
    localparam int SEG_W     = $clog2(MAX_SEGMENTS);
    localparam int WIN_W     = $clog2(MAX_SEGMENTS * 255 + 1);
    localparam int REM_W     = WIN_W + 1;
    localparam int PH_W      = PHASE_FRACTION_BITS + 1;
    localparam int PH_STEPS  = PHASE_FRACTION_BITS + 1;
    localparam int CONTACT_W = LEGS * MAX_SEGMENTS;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [1:0] REG_SEGMENT_COUNT     = 2'd0;
    localparam logic [1:0] REG_TICKS_PER_SEGMENT = 2'd1;
    localparam logic [1:0] REG_LEG_OFFSETS       = 2'd2;
    localparam logic [1:0] REG_LEG_DURATIONS     = 2'd3;

    localparam logic [CNT_W-1:0]          RST_SEGMENT_COUNT     = 5'd10;
    localparam logic [TPS_W-1:0]          RST_TICKS_PER_SEGMENT = 8'd30;
    localparam logic [LEGS*OFF_W-1:0]     RST_LEG_OFFSETS       = 16'd1360;
    localparam logic [LEGS*DUR_W-1:0]     RST_LEG_DURATIONS     = 20'd169125;

    localparam logic [PH_W-1:0] PHASE_ONE = PH_W'(1) << PHASE_FRACTION_BITS;

    typedef struct packed {
        logic [WIN_W-1:0]                  period;
        logic [TPS_W-1:0]                  tps;
        logic [CNT_W-1:0]                  nseg;
        logic [LANES-1:0][WIN_W-1:0]       start;
        logic [LANES-1:0][WIN_W-1:0]       len;
        logic [LEGS-1:0][SEG_W-1:0]        off;
        logic [LEGS-1:0][CNT_W-1:0]        dur;
    } lgps_cfg_t;

    typedef struct packed {
        logic [TICK_W-1:0] num;
        logic [TPS_W-1:0]  rem;
        logic [SEG_W-1:0]  seg;
    } div_word_t;

    typedef struct packed {
        logic [LANES-1:0][REM_W-1:0] rem;
        logic [LANES-1:0][PH_W-1:0]  q;
        logic [LANES-1:0]            zero;
        logic [SEG_W-1:0]            seg;
        logic [CONTACT_W-1:0]        contact;
    } ph_word_t;

endpackage

// ----- hw/rtl/lgps_tick_if.sv -----
// Input channel carrying one tick count word.
interface lgps_tick_if import lgps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] tick_count;

    modport source (output valid, output tick_count, input ready);
    modport sink   (input valid, input tick_count, output ready);
endinterface

// ----- hw/rtl/lgps_sched_if.sv -----
// Output channel carrying one schedule result word.
interface lgps_sched_if import lgps_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [SEG_W-1:0]     segment_index;
    logic [PH_W-1:0]      stance_phase_0;
    logic [PH_W-1:0]      stance_phase_1;
    logic [PH_W-1:0]      stance_phase_2;
    logic [PH_W-1:0]      stance_phase_3;
    logic [PH_W-1:0]      swing_phase_0;
    logic [PH_W-1:0]      swing_phase_1;
    logic [PH_W-1:0]      swing_phase_2;
    logic [PH_W-1:0]      swing_phase_3;
    logic [CONTACT_W-1:0] contact_table;

    modport source (output valid, output segment_index,
                    output stance_phase_0, output stance_phase_1,
                    output stance_phase_2, output stance_phase_3,
                    output swing_phase_0, output swing_phase_1,
                    output swing_phase_2, output swing_phase_3,
                    output contact_table, input ready);
    modport sink   (input valid, input segment_index,
                    input stance_phase_0, input stance_phase_1,
                    input stance_phase_2, input stance_phase_3,
                    input swing_phase_0, input swing_phase_1,
                    input swing_phase_2, input swing_phase_3,
                    input contact_table, output ready);
endinterface

// ----- hw/rtl/legged_gait_phase_scheduler.sv -----
// Gait phase scheduler top level: division chain, window stages, phase chain.
// One tick count word is taken per cycle while the output is not stalled; its result
// passes through 32 division cells that produce the segment and the tick within the
// segment, one stage that forms the cycle position and contact table, one stage that
// forms the elapsed ticks of each window, and 17 cells that produce the phase fractions
// (16 fraction bits). The pipeline holds one word per stage, and a stalled output backs
// up only as far as the stages are full. Configuration must be written while idle.
module legged_gait_phase_scheduler import lgps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    lgps_tick_if.sink         tick_in,
    lgps_sched_if.source      sched_out
);

    logic [CNT_W-1:0] nseg;
    logic [TPS_W-1:0] tps;
    lgps_cfg_t        cfg;

    lgps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .nseg    (nseg),
        .tps     (tps),
        .cfg     (cfg)
    );

    logic      div_v   [0:TICK_W];
    logic      div_rdy [0:TICK_W];
    div_word_t div_w   [0:TICK_W];

    assign div_v[0]       = tick_in.valid;
    assign div_w[0].num   = tick_in.tick_count;
    assign div_w[0].rem   = '0;
    assign div_w[0].seg   = '0;
    assign tick_in.ready  = div_rdy[0];

    for (genvar g = 0; g < TICK_W; g++)
    begin : g_div
        lgps_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .nseg      (nseg),
            .tps       (tps),
            .in_valid  (div_v[g]),
            .in_ready  (div_rdy[g]),
            .in_word   (div_w[g]),
            .out_valid (div_v[g+1]),
            .out_ready (div_rdy[g+1]),
            .out_word  (div_w[g+1])
        );
    end

    logic                 a_v_reg;
    logic [WIN_W-1:0]     a_r_reg;
    logic [SEG_W-1:0]     a_seg_reg;
    logic [CONTACT_W-1:0] a_contact_reg;
    logic [WIN_W-1:0]     a_r_next;
    logic [CONTACT_W-1:0] a_contact_next;
    logic                 a_ready;

    logic                 b_v_reg;
    ph_word_t             b_word_reg;
    ph_word_t             b_word_next;
    logic                 b_ready;

    logic     ph_v   [0:PH_STEPS];
    logic     ph_rdy [0:PH_STEPS];
    ph_word_t ph_w   [0:PH_STEPS];

    assign div_rdy[TICK_W] = a_ready;
    assign a_ready         = !a_v_reg || b_ready;

    always_comb
    begin
        logic [SEG_W+TPS_W-1:0] prod;
        logic [CNT_W:0]         it;
        logic [CNT_W:0]         prog;
        logic [CNT_W:0]         n6;
        logic [CNT_W:0]         o6;
        prod     = (SEG_W+TPS_W)'(div_w[TICK_W].seg) * (SEG_W+TPS_W)'(cfg.tps);
        a_r_next = prod[WIN_W-1:0] + WIN_W'(div_w[TICK_W].rem);
        n6       = (CNT_W+1)'(cfg.nseg);
        a_contact_next = '0;
        for (int i = 0; i < MAX_SEGMENTS; i++)
        begin
            for (int l = 0; l < LEGS; l++)
            begin
                it = (CNT_W+1)'(i) + (CNT_W+1)'(div_w[TICK_W].seg) + (CNT_W+1)'(1);
                if (it >= n6)
                    it = it - n6;
                o6 = (CNT_W+1)'(cfg.off[l]);
                prog = (it >= o6) ? (it - o6) : (it + n6 - o6);
                if ((CNT_W+1)'(i) < n6 && l < LEG_COUNT
                    && prog < (CNT_W+1)'(cfg.dur[l]))
                    a_contact_next[LEGS*i + l] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else if (a_ready)
            a_v_reg <= div_v[TICK_W];
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && div_v[TICK_W])
        begin
            a_r_reg       <= a_r_next;
            a_seg_reg     <= div_w[TICK_W].seg;
            a_contact_reg <= a_contact_next;
        end
    end

    assign b_ready = !b_v_reg || ph_rdy[0];

    always_comb
    begin
        logic [WIN_W-1:0] e;
        b_word_next         = '0;
        b_word_next.seg     = a_seg_reg;
        b_word_next.contact = a_contact_reg;
        for (int k = 0; k < LANES; k++)
        begin
            if (a_r_reg >= cfg.start[k])
                e = a_r_reg - cfg.start[k];
            else
                e = a_r_reg + cfg.period - cfg.start[k];
            b_word_next.rem[k]  = REM_W'(e);
            b_word_next.zero[k] = (cfg.len[k] == '0) || (e > cfg.len[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_v_reg <= 1'b0;
        else if (b_ready)
            b_v_reg <= a_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_v_reg)
            b_word_reg <= b_word_next;
    end

    assign ph_v[0] = b_v_reg;
    assign ph_w[0] = b_word_reg;

    for (genvar g = 0; g < PH_STEPS; g++)
    begin : g_phase
        lgps_phase_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .len       (cfg.len),
            .in_valid  (ph_v[g]),
            .in_ready  (ph_rdy[g]),
            .in_word   (ph_w[g]),
            .out_valid (ph_v[g+1]),
            .out_ready (ph_rdy[g+1]),
            .out_word  (ph_w[g+1])
        );
    end

    logic [LANES-1:0][PH_W-1:0] phase;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            if (ph_w[PH_STEPS].zero[k] || (k % LEGS) >= LEG_COUNT)
                phase[k] = '0;
            else
                phase[k] = ph_w[PH_STEPS].q[k];
        end
    end

    assign ph_rdy[PH_STEPS]         = sched_out.ready;
    assign sched_out.valid          = ph_v[PH_STEPS];
    assign sched_out.segment_index  = ph_w[PH_STEPS].seg;
    assign sched_out.contact_table  = ph_w[PH_STEPS].contact;
    assign sched_out.stance_phase_0 = phase[0];
    assign sched_out.stance_phase_1 = phase[1];
    assign sched_out.stance_phase_2 = phase[2];
    assign sched_out.stance_phase_3 = phase[3];
    assign sched_out.swing_phase_0  = phase[LEGS];
    assign sched_out.swing_phase_1  = phase[LEGS+1];
    assign sched_out.swing_phase_2  = phase[LEGS+2];
    assign sched_out.swing_phase_3  = phase[LEGS+3];

    a_phase_max: assert property (@(posedge clk) disable iff (!rst_n)
        sched_out.valid |-> (phase[0] <= PHASE_ONE && phase[LEGS] <= PHASE_ONE))
        else $error("phase above one");

    a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
        sched_out.valid |-> (CNT_W'(sched_out.segment_index) < cfg.nseg))
        else $error("segment index out of range");

    a_stance_swing: assert property (@(posedge clk) disable iff (!rst_n)
        (sched_out.valid && phase[0] != '0 && phase[0] != PHASE_ONE)
        |-> (phase[LEGS] == '0))
        else $error("leg in stance and swing at once");

endmodule

// ----- hw/rtl/lgps_cfg.sv -----
// APB register file and derived window timing.
module lgps_cfg import lgps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output logic [CNT_W-1:0]  nseg,
    output logic [TPS_W-1:0]  tps,
    output lgps_cfg_t         cfg
);

    logic [CNT_W-1:0]      seg_count_reg;
    logic [TPS_W-1:0]      tps_reg;
    logic [LEGS*OFF_W-1:0] offsets_reg;
    logic [LEGS*DUR_W-1:0] durations_reg;
    lgps_cfg_t             cfg_reg;
    lgps_cfg_t             cfg_next;
    logic                  wr;

    function automatic logic [SEG_W-1:0] mod_seg(input logic [OFF_W-1:0] v,
                                                 input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] rem;
        rem = '0;
        for (int i = OFF_W - 1; i >= 0; i--)
        begin
            rem = {rem[CNT_W-2:0], v[i]};
            if (rem >= n)
                rem = rem - n;
        end
        return rem[SEG_W-1:0];
    endfunction

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_count_reg <= RST_SEGMENT_COUNT;
            tps_reg       <= RST_TICKS_PER_SEGMENT;
            offsets_reg   <= RST_LEG_OFFSETS;
            durations_reg <= RST_LEG_DURATIONS;
        end
        else if (wr)
        begin
            unique case (paddr[3:2])
                REG_SEGMENT_COUNT:     seg_count_reg <= pwdata[CNT_W-1:0];
                REG_TICKS_PER_SEGMENT: tps_reg       <= pwdata[TPS_W-1:0];
                REG_LEG_OFFSETS:       offsets_reg   <= pwdata[LEGS*OFF_W-1:0];
                REG_LEG_DURATIONS:     durations_reg <= pwdata[LEGS*DUR_W-1:0];
                default:               seg_count_reg <= seg_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SEGMENT_COUNT:     prdata = DATA_W'(seg_count_reg);
            REG_TICKS_PER_SEGMENT: prdata = DATA_W'(tps_reg);
            REG_LEG_OFFSETS:       prdata = DATA_W'(offsets_reg);
            REG_LEG_DURATIONS:     prdata = DATA_W'(durations_reg);
            default:               prdata = '0;
        endcase
    end

    always_comb
    begin
        if (seg_count_reg == '0)
            nseg = CNT_W'(1);
        else if (seg_count_reg > CNT_W'(MAX_SEGMENTS))
            nseg = CNT_W'(MAX_SEGMENTS);
        else
            nseg = seg_count_reg;
        tps = (tps_reg == '0) ? TPS_W'(1) : tps_reg;
    end

    always_comb
    begin
        logic [SEG_W-1:0]       o;
        logic [CNT_W-1:0]       d;
        logic [CNT_W:0]         so;
        logic [CNT_W+TPS_W-1:0] prod;
        cfg_next      = '0;
        cfg_next.nseg = nseg;
        cfg_next.tps  = tps;
        prod          = nseg * tps;
        cfg_next.period = prod[WIN_W-1:0];
        for (int l = 0; l < LEGS; l++)
        begin
            o = mod_seg(offsets_reg[l*OFF_W +: OFF_W], nseg);
            d = durations_reg[l*DUR_W +: DUR_W];
            if (d > nseg)
                d = nseg;
            so = (CNT_W+1)'(o) + (CNT_W+1)'(d);
            if (so >= (CNT_W+1)'(nseg))
                so = so - (CNT_W+1)'(nseg);
            cfg_next.off[l] = o;
            cfg_next.dur[l] = d;
            prod = (CNT_W+TPS_W)'(o) * (CNT_W+TPS_W)'(tps);
            cfg_next.start[l] = prod[WIN_W-1:0];
            prod = (CNT_W+TPS_W)'(so) * (CNT_W+TPS_W)'(tps);
            cfg_next.start[LEGS+l] = prod[WIN_W-1:0];
            prod = (CNT_W+TPS_W)'(d) * (CNT_W+TPS_W)'(tps);
            cfg_next.len[l] = prod[WIN_W-1:0];
            prod = (CNT_W+TPS_W)'(nseg - d) * (CNT_W+TPS_W)'(tps);
            cfg_next.len[LEGS+l] = prod[WIN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/lgps_div_cell.sv -----
// One quotient bit of tick / ticks-per-segment, with quotient mod segment count.
module lgps_div_cell import lgps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] nseg,
    input  logic [TPS_W-1:0] tps,
    input  logic             in_valid,
    output logic             in_ready,
    input  div_word_t        in_word,
    output logic             out_valid,
    input  logic             out_ready,
    output div_word_t        out_word
);

    logic      valid_reg;
    div_word_t word_reg;
    div_word_t word_next;

    always_comb
    begin
        logic [TPS_W:0]   rem2;
        logic [CNT_W-1:0] m2;
        logic             ge;
        rem2 = {in_word.rem, in_word.num[TICK_W-1]};
        ge   = rem2 >= {1'b0, tps};
        if (ge)
            rem2 = rem2 - {1'b0, tps};
        m2 = {in_word.seg, ge};
        if (m2 >= nseg)
            m2 = m2 - nseg;
        word_next.num = {in_word.num[TICK_W-2:0], 1'b0};
        word_next.rem = rem2[TPS_W-1:0];
        word_next.seg = m2[SEG_W-1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ----- hw/rtl/lgps_phase_cell.sv -----
// One fraction bit of the sub-phase division, all windows side by side.
module lgps_phase_cell import lgps_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [LANES-1:0][WIN_W-1:0] len,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ph_word_t                    in_word,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ph_word_t                    out_word
);

    logic     valid_reg;
    ph_word_t word_reg;
    ph_word_t word_next;

    always_comb
    begin
        logic [REM_W-1:0] r;
        logic             ge;
        word_next = in_word;
        for (int k = 0; k < LANES; k++)
        begin
            r  = in_word.rem[k];
            ge = r >= REM_W'(len[k]);
            if (ge)
                r = r - REM_W'(len[k]);
            word_next.rem[k] = {r[REM_W-2:0], 1'b0};
            word_next.q[k]   = {in_word.q[k][PH_W-2:0], ge};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule
